>>> rtl/core/lpbc_pkg.sv
`timescale 1ns / 1ps
package lpbc_pkg;
    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_UNPIN = 2'd1,
        OP_FREE  = 2'd2,
        OP_ALLOC = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_PINNED = 2'd2
    } t_status;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [9:0]  tbl_id;
        logic [31:0] page_number;
        logic [3:0]  frame_index;
        logic        dirty_flag;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  frame;
        logic        hit;
        logic        writeback_valid;
        logic [9:0]  writeback_table;
        logic [31:0] writeback_page;
        logic        fetch_valid;
    } t_rsp;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_HDR,
        S_DONE
    } t_state;
endpackage

>>> rtl/core/lpbc_cell.sv
`timescale 1ns / 1ps
module lpbc_cell #(
    parameter int FW = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [FW-1:0] i_init,
    input  logic          i_load,
    input  logic [FW-1:0] i_prev,
    input  logic [FW-1:0] i_next,
    input  logic          i_take_prev,
    input  logic          i_take_next,
    input  logic          i_put,
    input  logic [FW-1:0] i_put_val,
    output logic [FW-1:0] o_frame
);
    logic [FW-1:0] r_frame;
    logic [FW-1:0] n_frame;

    always_comb begin
        n_frame = r_frame;
        if (i_put) begin
            n_frame = i_put_val;
        end else if (i_take_prev) begin
            n_frame = i_prev;
        end else if (i_take_next) begin
            n_frame = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_load) begin
            r_frame <= i_init;
        end else begin
            r_frame <= n_frame;
        end
    end

    assign o_frame = r_frame;
endmodule

>>> rtl/core/lru_page_buffer_controller.sv
`timescale 1ns / 1ps
// LRU page buffer controller with pinning.
// Channels: request on i_req, taken when i_start is high and o_busy low.
// One response per request appears on o_rsp for one cycle with o_done high;
// the receiver cannot stall and must take it in that cycle.
// Sequence: read and unpin pass S_LOOK, then S_DONE; free and alloc pass
// S_LOOK (invalidate, free only), then S_HDR (header refresh), then S_DONE.
// A new request is taken only once the previous one is done; o_busy stays
// high from the transfer through the o_done cycle.
// The recency order is a chain of FRAMES cells, position 0 is MRU; a move
// shifts the cells between the old and new position by one, all at once.
// Tag match and victim search are parallel compares over the frame array.
// Reset (synchronous, active low) clears tags, valid, dirty and pin bits and
// sets position i to frame i; the block is ready the cycle after reset.
module lru_page_buffer_controller #(
    parameter int FRAMES = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  lpbc_pkg::t_req         i_req,
    output logic                   o_busy,
    output logic                   o_done,
    output lpbc_pkg::t_rsp         o_rsp
);
    localparam int FW = (FRAMES > 1) ? $clog2(FRAMES) : 1;

    lpbc_pkg::t_state r_state, n_state;
    lpbc_pkg::t_req   r_req;
    lpbc_pkg::t_rsp   r_rsp, n_rsp;

    logic [FRAMES-1:0] r_valid, r_dirty, r_pin;
    logic [9:0]        r_ttab [FRAMES];
    logic [31:0]       r_tpg  [FRAMES];
    logic [FW-1:0]     w_ord  [FRAMES];

    // lookup
    logic [FRAMES-1:0] w_match;
    logic [31:0]       w_key_pg;
    logic              w_hit;
    logic [FW-1:0]     w_hf;
    always_comb begin
        w_key_pg = (r_state == lpbc_pkg::S_HDR) ? 32'd0 : r_req.page_number;
        w_hit = 1'b0;
        w_hf  = '0;
        for (int f = 0; f < FRAMES; f++) begin
            w_match[f] = r_valid[f] && r_ttab[f] == r_req.tbl_id && r_tpg[f] == w_key_pg;
        end
        for (int f = FRAMES - 1; f >= 0; f--) begin
            if (w_match[f]) begin
                w_hit = 1'b1;
                w_hf  = FW'(f);
            end
        end
    end

    // victim: least recent unpinned
    logic          w_vok;
    logic [FW-1:0] w_vic;
    always_comb begin
        w_vok = 1'b0;
        w_vic = '0;
        for (int p = 0; p < FRAMES; p++) begin
            if (!r_pin[w_ord[p]]) begin
                w_vok = 1'b1;
                w_vic = w_ord[p];
            end
        end
    end

    // move control
    logic          w_mru, w_lru;
    logic [FW-1:0] w_mf;
    logic [FW-1:0] w_pos;
    always_comb begin
        w_pos = '0;
        for (int p = 0; p < FRAMES; p++) begin
            if (w_ord[p] == w_mf) begin
                w_pos = FW'(p);
            end
        end
    end

    // look stage decisions
    logic w_is_read, w_is_unpin, w_is_free, w_in_range;
    assign w_is_read  = r_req.opcode == lpbc_pkg::OP_READ;
    assign w_is_unpin = r_req.opcode == lpbc_pkg::OP_UNPIN;
    assign w_is_free  = r_req.opcode == lpbc_pkg::OP_FREE;
    assign w_in_range = 32'(r_req.frame_index) < 32'(FRAMES);

    always_comb begin
        w_mru = 1'b0;
        w_lru = 1'b0;
        w_mf  = '0;
        if (r_state == lpbc_pkg::S_LOOK) begin
            if (w_is_read) begin
                if (w_hit) begin
                    w_mf  = w_hf;
                    w_mru = !r_pin[w_hf];
                end else begin
                    w_mf  = w_vic;
                    w_mru = w_vok;
                end
            end else if (w_is_free && w_hit) begin
                w_mf  = w_hf;
                w_lru = 1'b1;
            end
        end else if (r_state == lpbc_pkg::S_HDR && w_hit && !r_pin[w_hf]) begin
            w_mf  = w_hf;
            w_mru = 1'b1;
        end
    end

    for (genvar p = 0; p < FRAMES; p++) begin : g_cell
        logic [FW-1:0] w_prev, w_next;
        logic          w_tp, w_tn, w_put;
        assign w_prev = (p == 0) ? w_ord[0] : w_ord[(p == 0) ? 0 : p - 1];
        assign w_next = (p == FRAMES - 1) ? w_ord[p] : w_ord[(p == FRAMES - 1) ? p : p + 1];
        assign w_tp  = w_mru && FW'(p) <= w_pos && p != 0;
        assign w_tn  = w_lru && FW'(p) >= w_pos && p != FRAMES - 1;
        assign w_put = (w_mru && p == 0) || (w_lru && p == FRAMES - 1);
        lpbc_cell #(.FW(FW)) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_init      (FW'(p)),
            .i_load      (1'b0),
            .i_prev      (w_prev),
            .i_next      (w_next),
            .i_take_prev (w_tp),
            .i_take_next (w_tn),
            .i_put       (w_put),
            .i_put_val   (w_mf),
            .o_frame     (w_ord[p])
        );
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lpbc_pkg::S_IDLE: if (i_start) n_state = lpbc_pkg::S_LOOK;
            lpbc_pkg::S_LOOK: n_state = (w_is_read || w_is_unpin) ? lpbc_pkg::S_DONE
                                                                 : lpbc_pkg::S_HDR;
            lpbc_pkg::S_HDR:  n_state = lpbc_pkg::S_DONE;
            lpbc_pkg::S_DONE: n_state = lpbc_pkg::S_IDLE;
            default:          n_state = lpbc_pkg::S_IDLE;
        endcase
    end

    // response
    always_comb begin
        n_rsp = r_rsp;
        unique case (r_state)
            lpbc_pkg::S_LOOK: begin
                n_rsp = '0;
                if (w_is_read) begin
                    if (w_hit) begin
                        n_rsp.frame = 4'(w_hf);
                        n_rsp.hit   = 1'b1;
                        if (r_pin[w_hf]) n_rsp.status = lpbc_pkg::ST_PINNED;
                    end else if (!w_vok) begin
                        n_rsp.status = lpbc_pkg::ST_FULL;
                    end else begin
                        n_rsp.frame = 4'(w_vic);
                        n_rsp.fetch_valid = 1'b1;
                        if (r_valid[w_vic] && r_dirty[w_vic]) begin
                            n_rsp.writeback_valid = 1'b1;
                            n_rsp.writeback_table = r_ttab[w_vic];
                            n_rsp.writeback_page  = r_tpg[w_vic];
                        end
                    end
                end else if (w_is_unpin) begin
                    n_rsp.frame = r_req.frame_index;
                end
            end
            lpbc_pkg::S_HDR: begin
                if (w_hit) begin
                    n_rsp.frame = 4'(w_hf);
                    n_rsp.hit   = 1'b1;
                    if (r_pin[w_hf]) begin
                        n_rsp.status = lpbc_pkg::ST_PINNED;
                    end else begin
                        n_rsp.fetch_valid = 1'b1;
                        if (r_dirty[w_hf]) begin
                            n_rsp.writeback_valid = 1'b1;
                            n_rsp.writeback_table = r_ttab[w_hf];
                            n_rsp.writeback_page  = r_tpg[w_hf];
                        end
                    end
                end
            end
            default: n_rsp = r_rsp;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lpbc_pkg::S_IDLE;
            r_valid <= '0;
            r_dirty <= '0;
            r_pin   <= '0;
            for (int f = 0; f < FRAMES; f++) begin
                r_ttab[f] <= '0;
                r_tpg[f]  <= '0;
            end
        end else begin
            r_state <= n_state;
            if (r_state == lpbc_pkg::S_LOOK) begin
                if (w_is_read) begin
                    if (w_hit) begin
                        r_pin[w_hf] <= 1'b1;
                    end else if (w_vok) begin
                        r_valid[w_vic] <= 1'b1;
                        r_ttab[w_vic]  <= r_req.tbl_id;
                        r_tpg[w_vic]   <= r_req.page_number;
                        r_dirty[w_vic] <= 1'b0;
                        r_pin[w_vic]   <= 1'b1;
                    end
                end else if (w_is_unpin) begin
                    if (w_in_range) begin
                        if (r_valid[FW'(r_req.frame_index)] && r_req.dirty_flag) begin
                            r_dirty[FW'(r_req.frame_index)] <= 1'b1;
                        end
                        r_pin[FW'(r_req.frame_index)] <= 1'b0;
                    end
                end else if (w_is_free && w_hit) begin
                    r_valid[w_hf] <= 1'b0;
                    r_dirty[w_hf] <= 1'b0;
                    r_pin[w_hf]   <= 1'b0;
                end
            end else if (r_state == lpbc_pkg::S_HDR && w_hit && !r_pin[w_hf]) begin
                r_dirty[w_hf] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == lpbc_pkg::S_IDLE && i_start) begin
            r_req <= i_req;
        end
        r_rsp <= n_rsp;
    end

    assign o_busy = r_state != lpbc_pkg::S_IDLE;
    assign o_done = r_state == lpbc_pkg::S_DONE;
    assign o_rsp  = r_rsp;
endmodule

>>> bench/tb_lru_page_buffer_controller.sv
`timescale 1ns / 1ps
module tb_lru_page_buffer_controller;
    localparam int NFR = 16;
    localparam int WATCH_LIMIT = 2000;

    logic           i_clk;
    logic           i_rst_n;
    logic           i_start;
    lpbc_pkg::t_req i_req;
    logic           o_busy;
    logic           o_done;
    lpbc_pkg::t_rsp o_rsp;

    lru_page_buffer_controller #(.FRAMES(NFR)) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_start),
        .i_req(i_req),
        .o_busy(o_busy),
        .o_done(o_done),
        .o_rsp(o_rsp)
    );

    logic        fr_valid [NFR];
    logic [9:0]  fr_table [NFR];
    logic [31:0] fr_page  [NFR];
    logic        fr_dirty [NFR];
    logic        fr_pin   [NFR];
    logic [3:0]  recency  [NFR];

    lpbc_pkg::t_rsp pending_rsp[$];
    int   mismatches;
    int   rsp_count;
    int   sent_count;
    int   gap_pct;
    int   idle_cycles;
    int   op_count[4];
    int   status_count[3];

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic int find_frame(logic [9:0] tbl, logic [31:0] pg);
        for (int f = 0; f < NFR; f++)
            if (fr_valid[f] && fr_table[f] == tbl && fr_page[f] == pg) return f;
        return -1;
    endfunction

    function automatic int slot_of(int f);
        for (int p = 0; p < NFR; p++)
            if (recency[p] == f[3:0]) return p;
        return 0;
    endfunction

    function automatic void promote(int f);
        int p;
        p = slot_of(f);
        for (; p > 0; p--) recency[p] = recency[p-1];
        recency[0] = f[3:0];
    endfunction

    function automatic void demote(int f);
        int p;
        p = slot_of(f);
        for (; p < NFR - 1; p++) recency[p] = recency[p+1];
        recency[NFR-1] = f[3:0];
    endfunction

    function automatic void clear_frames();
        for (int i = 0; i < NFR; i++) begin
            fr_valid[i] = 1'b0;
            fr_table[i] = '0;
            fr_page[i]  = '0;
            fr_dirty[i] = 1'b0;
            fr_pin[i]   = 1'b0;
            recency[i]  = i[3:0];
        end
    endfunction

    function automatic lpbc_pkg::t_rsp buffer_response(lpbc_pkg::t_req rq);
        lpbc_pkg::t_rsp r;
        int f;
        int h;
        r = '0;
        case (lpbc_pkg::t_opcode'(rq.opcode))
            lpbc_pkg::OP_READ: begin
                f = find_frame(rq.tbl_id, rq.page_number);
                if (f >= 0) begin
                    r.frame = f[3:0];
                    r.hit = 1'b1;
                    if (fr_pin[f]) r.status = lpbc_pkg::ST_PINNED;
                    else begin
                        fr_pin[f] = 1'b1;
                        promote(f);
                    end
                    return r;
                end
                for (int p = NFR - 1; p >= 0; p--)
                    if (!fr_pin[recency[p]]) begin
                        f = recency[p];
                        break;
                    end
                if (f < 0) begin
                    r.status = lpbc_pkg::ST_FULL;
                    return r;
                end
                r.frame = f[3:0];
                if (fr_valid[f] && fr_dirty[f]) begin
                    r.writeback_valid = 1'b1;
                    r.writeback_table = fr_table[f];
                    r.writeback_page  = fr_page[f];
                end
                r.fetch_valid = 1'b1;
                fr_valid[f] = 1'b1;
                fr_table[f] = rq.tbl_id;
                fr_page[f]  = rq.page_number;
                fr_dirty[f] = 1'b0;
                fr_pin[f]   = 1'b1;
                promote(f);
                return r;
            end
            lpbc_pkg::OP_UNPIN: begin
                r.frame = rq.frame_index;
                if (fr_valid[rq.frame_index])
                    fr_dirty[rq.frame_index] = fr_dirty[rq.frame_index] | rq.dirty_flag;
                fr_pin[rq.frame_index] = 1'b0;
                return r;
            end
            default: begin
                if (lpbc_pkg::t_opcode'(rq.opcode) == lpbc_pkg::OP_FREE) begin
                    f = find_frame(rq.tbl_id, rq.page_number);
                    if (f >= 0) begin
                        fr_valid[f] = 1'b0;
                        fr_dirty[f] = 1'b0;
                        fr_pin[f]   = 1'b0;
                        demote(f);
                    end
                end
                h = find_frame(rq.tbl_id, 32'd0);
                if (h < 0) return r;
                r.frame = h[3:0];
                r.hit = 1'b1;
                if (fr_pin[h]) begin
                    r.status = lpbc_pkg::ST_PINNED;
                    return r;
                end
                if (fr_dirty[h]) begin
                    r.writeback_valid = 1'b1;
                    r.writeback_table = fr_table[h];
                    r.writeback_page  = fr_page[h];
                    fr_dirty[h] = 1'b0;
                end
                r.fetch_valid = 1'b1;
                promote(h);
                return r;
            end
        endcase
    endfunction

    task automatic send_request(lpbc_pkg::t_req rq);
        while ($urandom_range(99) < gap_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_req   <= rq;
        i_start <= 1'b1;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        pending_rsp.push_back(buffer_response(rq));
        op_count[rq.opcode]++;
        sent_count++;
    endtask

    function automatic lpbc_pkg::t_req make_req(lpbc_pkg::t_opcode op, logic [9:0] tbl,
                                                logic [31:0] pg, logic [3:0] fi,
                                                logic dfl);
        lpbc_pkg::t_req rq;
        rq.opcode = op;
        rq.tbl_id = tbl;
        rq.page_number = pg;
        rq.frame_index = fi;
        rq.dirty_flag = dfl;
        return rq;
    endfunction

    always @(posedge i_clk) begin
        lpbc_pkg::t_rsp want;
        if (i_rst_n) begin
            idle_cycles <= (o_done || (i_start && !o_busy)) ? 0 : idle_cycles + 1;
            if (o_done) begin
                rsp_count++;
                if (pending_rsp.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected response %h", o_rsp);
                end else begin
                    want = pending_rsp.pop_front();
                    if (o_rsp.status < 3) status_count[o_rsp.status]++;
                    if (o_rsp !== want) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch: st %0d/%0d fr %0d/%0d hit %0d/%0d",
                                want.status, o_rsp.status, want.frame, o_rsp.frame,
                                want.hit, o_rsp.hit);
                            $display("  wb %0d/%0d %0d/%0d %h/%h fetch %0d/%0d",
                                want.writeback_valid, o_rsp.writeback_valid,
                                want.writeback_table, o_rsp.writeback_table,
                                want.writeback_page, o_rsp.writeback_page,
                                want.fetch_valid, o_rsp.fetch_valid);
                        end
                    end
                end
            end
            if (idle_cycles > WATCH_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    task automatic drain_responses();
        i_start <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed();
        send_request(make_req(lpbc_pkg::OP_ALLOC, 10'd0, 32'd0, 4'd0, 1'b0));
        send_request(make_req(lpbc_pkg::OP_READ, 10'd1023, 32'hFFFF_FFFF, 4'd0, 1'b0));
        send_request(make_req(lpbc_pkg::OP_READ, 10'd1023, 32'hFFFF_FFFF, 4'd0, 1'b0));
        send_request(make_req(lpbc_pkg::OP_READ, 10'd5, 32'd0, 4'd0, 1'b0));
        send_request(make_req(lpbc_pkg::OP_FREE, 10'd5, 32'd7, 4'd0, 1'b0));
        send_request(make_req(lpbc_pkg::OP_UNPIN, 10'd0, 32'd0, 4'd14, 1'b1));
        send_request(make_req(lpbc_pkg::OP_UNPIN, 10'd0, 32'd0, 4'd15, 1'b1));
        send_request(make_req(lpbc_pkg::OP_ALLOC, 10'd5, 32'h1234, 4'd0, 1'b0));
        send_request(make_req(lpbc_pkg::OP_ALLOC, 10'd5, 32'd0, 4'd0, 1'b0));
        send_request(make_req(lpbc_pkg::OP_UNPIN, 10'd0, 32'd0, 4'd3, 1'b1));
        for (int i = 0; i < 15; i++)
            send_request(make_req(lpbc_pkg::OP_READ, 10'd9, 32'(i + 1), 4'd0, 1'b0));
        send_request(make_req(lpbc_pkg::OP_READ, 10'd9, 32'd100, 4'd0, 1'b0));
        send_request(make_req(lpbc_pkg::OP_UNPIN, 10'd0, 32'd0, 4'd0, 1'b0));
        send_request(make_req(lpbc_pkg::OP_READ, 10'd9, 32'd101, 4'd0, 1'b0));
        send_request(make_req(lpbc_pkg::OP_FREE, 10'd9, 32'd101, 4'd0, 1'b0));
        send_request(make_req(lpbc_pkg::OP_FREE, 10'd9, 32'd999, 4'd0, 1'b0));
        drain_responses();
    endtask

    task automatic test_random(int count);
        lpbc_pkg::t_req rq;
        int sel;
        for (int i = 0; i < count; i++) begin
            sel = $urandom_range(99);
            rq = '0;
            rq.tbl_id = 10'($urandom_range(3));
            rq.page_number = 32'($urandom_range(5));
            if (sel < 5) begin
                rq.tbl_id = 10'($urandom);
                rq.page_number = 32'($urandom);
            end
            rq.frame_index = 4'($urandom);
            rq.dirty_flag = 1'($urandom);
            if (sel < 40) rq.opcode = lpbc_pkg::OP_READ;
            else if (sel < 75) rq.opcode = lpbc_pkg::OP_UNPIN;
            else if (sel < 88) rq.opcode = lpbc_pkg::OP_FREE;
            else rq.opcode = lpbc_pkg::OP_ALLOC;
            send_request(rq);
            if (i == count / 2) drain_responses();
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_req = '0;
        mismatches = 0;
        rsp_count = 0;
        sent_count = 0;
        idle_cycles = 0;
        gap_pct = 18;
        clear_frames();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(330);
        gap_pct = 59;
        test_random(330);
        gap_pct = 0;
        test_random(330);
        drain_responses();
        repeat (10) @(posedge i_clk);
        $display("Covered %0d requests: read %0d unpin %0d free %0d alloc %0d",
                 sent_count, op_count[0], op_count[1], op_count[2], op_count[3]);
        $display("Responses ok %0d full %0d pinned %0d, mismatches %0d",
                 status_count[0], status_count[1], status_count[2], mismatches);
        if (mismatches == 0 && pending_rsp.size() == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end
endmodule
